[hw/rtl/tx_wfp_pkg.sv]
// Shared types, codes and state helpers for the transaction wire-format parser.
package tx_wfp_pkg;

	localparam int CNT_W    = 14;
	localparam int VAL_W    = 64;
	localparam int MAX_EV   = 4;
	localparam int QDEPTH   = 8;
	localparam int QPTR_W   = 3;
	localparam int CFG_IDX_W = 3;

	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [4:0] {
		PH_VERSION, PH_MARKER, PH_IN_COUNT, PH_PREVOUT, PH_PREV_INDEX, PH_SIG_LEN,
		PH_SIG, PH_SEQ, PH_OUT_COUNT, PH_AMOUNT, PH_PK_LEN, PH_PK, PH_WIT_COUNT,
		PH_WIT_LEN, PH_WIT, PH_LOCK, PH_DONE
	} phase_t;

	// event kinds
	localparam logic [4:0] K_VERSION   = 5'd0;
	localparam logic [4:0] K_MARKER    = 5'd1;
	localparam logic [4:0] K_IN_COUNT  = 5'd2;
	localparam logic [4:0] K_PREVOUT   = 5'd3;
	localparam logic [4:0] K_PREV_IDX  = 5'd4;
	localparam logic [4:0] K_SIG_LEN   = 5'd5;
	localparam logic [4:0] K_SIG       = 5'd6;
	localparam logic [4:0] K_SEQ       = 5'd7;
	localparam logic [4:0] K_OUT_COUNT = 5'd8;
	localparam logic [4:0] K_AMOUNT    = 5'd9;
	localparam logic [4:0] K_PK_LEN    = 5'd10;
	localparam logic [4:0] K_PK        = 5'd11;
	localparam logic [4:0] K_WIT_COUNT = 5'd12;
	localparam logic [4:0] K_WIT_LEN   = 5'd13;
	localparam logic [4:0] K_WIT       = 5'd14;
	localparam logic [4:0] K_LOCK      = 5'd15;
	localparam logic [4:0] K_ACCEPT    = 5'd16;
	localparam logic [4:0] K_ERROR     = 5'd17;

	// error codes
	localparam logic [2:0] E_NONE      = 3'd0;
	localparam logic [2:0] E_TRUNC     = 3'd1;
	localparam logic [2:0] E_INPUTS    = 3'd2;
	localparam logic [2:0] E_OUTPUTS   = 3'd3;
	localparam logic [2:0] E_SCRIPT    = 3'd4;
	localparam logic [2:0] E_WIT_ITEMS = 3'd5;
	localparam logic [2:0] E_WIT_LEN   = 3'd6;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] R_MAX_INPUTS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] R_MAX_OUTPUTS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] R_MAX_SCRIPT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] R_MAX_WITEMS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] R_MAX_WLEN    = 3'd4;

	localparam logic [7:0] CS_FD = 8'hFD;
	localparam logic [7:0] CS_FE = 8'hFE;
	localparam cnt_t PREVOUT_LEN = 14'd32;

	typedef struct packed {
		logic [4:0]       event_kind;
		logic [VAL_W-1:0] event_value;
		cnt_t             entry_index;
		cnt_t             item_index;
		logic [2:0]       error_code;
		logic             last_event;
	} evt_t;

	typedef struct packed {
		phase_t           phase;
		logic [3:0]       fbl;
		logic [2:0]       fshift;
		logic [VAL_W-1:0] acc;
		cnt_t             in_cnt;
		cnt_t             ent_cnt;
		cnt_t             ent_tot;
		cnt_t             wit_cnt;
		cnt_t             wit_tot;
		cnt_t             pay_len;
		cnt_t             pay_left;
		logic             segwit;
		logic             zpend;
		logic             finished;
	} parse_st_t;

	function automatic evt_t mk_ev(logic [4:0] k, logic [VAL_W-1:0] v, cnt_t e, cnt_t i,
			logic [2:0] err);
		evt_t r;
		r.event_kind  = k;
		r.event_value = v;
		r.entry_index = e;
		r.item_index  = i;
		r.error_code  = err;
		r.last_event  = 1'b0;
		return r;
	endfunction

	function automatic parse_st_t st_reset();
		parse_st_t s;
		s = '0;
		s.phase = PH_VERSION;
		s.fbl   = 4'd4;
		return s;
	endfunction

	function automatic parse_st_t start_fixed(parse_st_t s, phase_t ph, logic [3:0] n);
		parse_st_t r;
		r = s;
		r.phase = ph; r.fbl = n; r.fshift = '0; r.acc = '0;
		return r;
	endfunction

	function automatic parse_st_t start_var(parse_st_t s, phase_t ph);
		return start_fixed(s, ph, 4'd0);
	endfunction

	function automatic parse_st_t start_payload(parse_st_t s, phase_t ph, cnt_t len);
		parse_st_t r;
		r = s;
		r.phase = ph; r.pay_len = len; r.pay_left = len;
		return r;
	endfunction

	function automatic parse_st_t after_outputs(parse_st_t s);
		parse_st_t r;
		r = s;
		r.ent_cnt = '0;
		if (r.segwit && r.in_cnt != '0) r = start_var(r, PH_WIT_COUNT);
		else r = start_fixed(r, PH_LOCK, 4'd4);
		return r;
	endfunction

	function automatic parse_st_t next_input(parse_st_t s);
		parse_st_t r;
		r = s;
		r.ent_cnt = r.ent_cnt + 1'b1;
		if (r.ent_cnt < r.ent_tot) r = start_payload(r, PH_PREVOUT, PREVOUT_LEN);
		else r = start_var(r, PH_OUT_COUNT);
		return r;
	endfunction

	function automatic parse_st_t next_output(parse_st_t s);
		parse_st_t r;
		r = s;
		r.ent_cnt = r.ent_cnt + 1'b1;
		if (r.ent_cnt < r.ent_tot) r = start_fixed(r, PH_AMOUNT, 4'd8);
		else r = after_outputs(r);
		return r;
	endfunction

	function automatic parse_st_t next_wit_input(parse_st_t s);
		parse_st_t r;
		r = s;
		r.ent_cnt = r.ent_cnt + 1'b1;
		if (r.ent_cnt < r.in_cnt) r = start_var(r, PH_WIT_COUNT);
		else r = start_fixed(r, PH_LOCK, 4'd4);
		return r;
	endfunction

	function automatic parse_st_t next_item(parse_st_t s);
		parse_st_t r;
		r = s;
		r.wit_cnt = r.wit_cnt + 1'b1;
		if (r.wit_cnt < r.wit_tot) r = start_var(r, PH_WIT_LEN);
		else r = next_wit_input(r);
		return r;
	endfunction

	// count or length beyond its limit
	function automatic logic over(logic [VAL_W-1:0] v, cnt_t lim);
		return (v[VAL_W-1:CNT_W] != '0) || (v[CNT_W-1:0] > lim);
	endfunction

endpackage

[hw/rtl/tx_wfp_if.sv]
// Byte input channel and event output channel.
interface tx_wfp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;
	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface tx_wfp_evt_if;
	import tx_wfp_pkg::*;
	logic             valid;
	logic             ready;
	logic [4:0]       event_kind;
	logic [VAL_W-1:0] event_value;
	cnt_t             entry_index;
	cnt_t             item_index;
	logic [2:0]       error_code;
	logic             last_event;
	modport source (output valid, output event_kind, output event_value, output entry_index,
		output item_index, output error_code, output last_event, input ready);
	modport sink (input valid, input event_kind, input event_value, input entry_index,
		input item_index, input error_code, input last_event, output ready);
endinterface

[hw/rtl/tx_wfp_evq.sv]
// Event queue: takes up to four events per cycle, delivers one per transfer.
module tx_wfp_evq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [2:0]                  push_n,
	input  tx_wfp_pkg::evt_t            push_ev [tx_wfp_pkg::MAX_EV],
	output logic                        space_ok,
	tx_wfp_evt_if.source                evt
);
	import tx_wfp_pkg::*;

	evt_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic              pop;

	assign pop      = evt.valid && evt.ready;
	assign space_ok = cnt_q <= (QPTR_W+1)'(QDEPTH - MAX_EV);
	assign evt.valid = cnt_q != '0;

	assign evt.event_kind  = mem_q[rd_q].event_kind;
	assign evt.event_value = mem_q[rd_q].event_value;
	assign evt.entry_index = mem_q[rd_q].entry_index;
	assign evt.item_index  = mem_q[rd_q].item_index;
	assign evt.error_code  = mem_q[rd_q].error_code;
	assign evt.last_event  = mem_q[rd_q].last_event;

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_EV; i++) begin
			if (3'(i) < push_n) mem_q[wr_q + QPTR_W'(i)] <= push_ev[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QPTR_W'(push_n);
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QPTR_W+1)'(push_n) - (QPTR_W+1)'(pop);
		end
	end

endmodule

[hw/rtl/tx_wire_format_parser.sv]
// Top level: byte-serial parser for the segregated-witness transaction format.
// Path: a byte is registered in the input stage at its transfer and parsed there; its
// events are written to the event queue once the queue has room, and offered from it.
// Throughput: one byte per cycle while the event queue (8 deep) has room for four
// events; the output drains one event per transfer, so event-heavy bytes set the pace.
// Reset (arst_n low): parse state returns to expecting the version, the limit
// registers take their defaults (10000, 10000, 10000, 500, 10000), queue empties.
module tx_wire_format_parser #(
	parameter int COUNT_BITS = 14
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tx_wfp_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [tx_wfp_pkg::CNT_W-1:0]     cfg_data,
	tx_wfp_in_if.sink                        in_ch,
	tx_wfp_evt_if.source                     out_ch
);
	import tx_wfp_pkg::*;

	// cap that the count width puts on every limit
	localparam cnt_t CAP = (COUNT_BITS >= CNT_W) ? {CNT_W{1'b1}} :
		CNT_W'((64'd1 << COUNT_BITS) - 64'd1);

	// limit registers
	cnt_t max_in_q, max_out_q, max_script_q, max_witems_q, max_wlen_q;
	cnt_t lim_in, lim_out, lim_script, lim_witems, lim_wlen;

	// input stage
	logic       v_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	parse_st_t  st_q;
	parse_st_t  st_d;
	evt_t       evs [MAX_EV];
	logic [2:0] n_ev;
	logic       space_ok;
	logic       fire;

	assign fire        = v_s1 && space_ok;
	assign in_ch.ready = !v_s1 || space_ok;

	assign lim_in     = (max_in_q     < CAP) ? max_in_q     : CAP;
	assign lim_out    = (max_out_q    < CAP) ? max_out_q    : CAP;
	assign lim_script = (max_script_q < CAP) ? max_script_q : CAP;
	assign lim_witems = (max_witems_q < CAP) ? max_witems_q : CAP;
	assign lim_wlen   = (max_wlen_q   < CAP) ? max_wlen_q   : CAP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_in_q     <= 14'd10000;
			max_out_q    <= 14'd10000;
			max_script_q <= 14'd10000;
			max_witems_q <= 14'd500;
			max_wlen_q   <= 14'd10000;
		end else if (cfg_we) begin
			case (cfg_idx)
				R_MAX_INPUTS:  max_in_q     <= cfg_data;
				R_MAX_OUTPUTS: max_out_q    <= cfg_data;
				R_MAX_SCRIPT:  max_script_q <= cfg_data;
				R_MAX_WITEMS:  max_witems_q <= cfg_data;
				R_MAX_WLEN:    max_wlen_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1 <= in_ch.in_byte;
			last_s1 <= in_ch.in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= st_reset();
		end else if (fire) begin
			st_q <= st_d;
		end
	end

	// One byte's worth of parsing. Flags chain the steps in model order:
	// phase dispatch, then compact-size handling, then byte gathering,
	// then field completion, then end-of-frame.
	always_comb begin
		parse_st_t        s;
		logic             do_var;
		logic             do_gather;
		logic             do_done;
		logic [VAL_W-1:0] v;
		cnt_t             off;
		s         = st_q;
		do_var    = 1'b0;
		do_gather = 1'b0;
		do_done   = 1'b0;
		v         = '0;
		off       = st_q.pay_len - st_q.pay_left;
		n_ev      = '0;
		for (int i = 0; i < MAX_EV; i++) evs[i] = '0;

		if (!s.finished) begin
			case (s.phase)
				PH_VERSION, PH_PREV_INDEX, PH_SEQ, PH_AMOUNT, PH_LOCK: do_gather = 1'b1;
				PH_IN_COUNT, PH_SIG_LEN, PH_OUT_COUNT, PH_PK_LEN, PH_WIT_COUNT,
				PH_WIT_LEN: do_var = 1'b1;
				PH_MARKER: begin
					if (s.zpend) begin
						s.zpend = 1'b0;
						if (byte_s1 == 8'h01) begin
							s.segwit = 1'b1;
							evs[n_ev[1:0]] = mk_ev(K_MARKER, 64'd1, '0, '0, E_NONE);
							n_ev = n_ev + 1'b1;
							s = start_var(s, PH_IN_COUNT);
						end else begin
							// no marker: input count is zero, byte opens output count
							evs[n_ev[1:0]] = mk_ev(K_IN_COUNT, '0, '0, '0, E_NONE);
							n_ev = n_ev + 1'b1;
							s.in_cnt = '0; s.ent_tot = '0; s.ent_cnt = '0;
							s = start_var(s, PH_OUT_COUNT);
							do_var = 1'b1;
						end
					end else if (byte_s1 == 8'h00) begin
						s.zpend = 1'b1;
					end else begin
						s = start_var(s, PH_IN_COUNT);
						do_var = 1'b1;
					end
				end
				PH_PREVOUT, PH_SIG, PH_PK, PH_WIT: begin
					case (s.phase)
						PH_PREVOUT: evs[n_ev[1:0]] = mk_ev(K_PREVOUT, 64'(byte_s1), s.ent_cnt,
							off, E_NONE);
						PH_SIG: evs[n_ev[1:0]] = mk_ev(K_SIG, 64'(byte_s1), s.ent_cnt, off,
							E_NONE);
						PH_PK: evs[n_ev[1:0]] = mk_ev(K_PK, 64'(byte_s1), s.ent_cnt, off,
							E_NONE);
						default: evs[n_ev[1:0]] = mk_ev(K_WIT, 64'(byte_s1), s.ent_cnt, off,
							E_NONE);
					endcase
					n_ev = n_ev + 1'b1;
					if (s.pay_left != '0) s.pay_left = s.pay_left - 1'b1;
					if (s.pay_left == '0) begin
						case (s.phase)
							PH_PREVOUT: s = start_fixed(s, PH_PREV_INDEX, 4'd4);
							PH_SIG:     s = start_fixed(s, PH_SEQ, 4'd4);
							PH_PK:      s = next_output(s);
							default:    s = next_item(s);
						endcase
					end
				end
				default: begin
					s.finished = 1'b1;
					s.phase    = PH_DONE;
				end
			endcase
		end

		// compact-size prefix or single-byte value
		if (do_var) begin
			if (s.fbl != '0) begin
				do_gather = 1'b1;
			end else if (byte_s1 < CS_FD) begin
				do_done = 1'b1;
				v = 64'(byte_s1);
			end else begin
				s.fbl    = (byte_s1 == CS_FD) ? 4'd2 : (byte_s1 == CS_FE) ? 4'd4 : 4'd8;
				s.fshift = '0;
				s.acc    = '0;
			end
		end

		// little-endian byte gather
		if (do_gather) begin
			s.acc[s.fshift*8 +: 8] = s.acc[s.fshift*8 +: 8] | byte_s1;
			s.fshift = s.fshift + 1'b1;
			if (s.fbl != '0) s.fbl = s.fbl - 1'b1;
			if (s.fbl == '0) begin
				do_done = 1'b1;
				v = s.acc;
			end
		end

		// field complete: emit, check limit, move on
		if (do_done) begin
			case (s.phase)
				PH_VERSION: begin
					evs[n_ev[1:0]] = mk_ev(K_VERSION, {32'd0, v[31:0]}, '0, '0, E_NONE);
					n_ev = n_ev + 1'b1;
					s.phase = PH_MARKER;
					s.zpend = 1'b0;
				end
				PH_IN_COUNT: begin
					evs[n_ev[1:0]] = mk_ev(K_IN_COUNT, v, '0, '0, E_NONE);
					n_ev = n_ev + 1'b1;
					if (over(v, lim_in)) begin
						evs[n_ev[1:0]] = mk_ev(K_ERROR, '0, '0, '0, E_INPUTS);
						n_ev = n_ev + 1'b1;
						s.finished = 1'b1; s.phase = PH_DONE;
					end else begin
						s.in_cnt = v[CNT_W-1:0]; s.ent_tot = v[CNT_W-1:0]; s.ent_cnt = '0;
						if (v == '0) s = start_var(s, PH_OUT_COUNT);
						else s = start_payload(s, PH_PREVOUT, PREVOUT_LEN);
					end
				end
				PH_PREV_INDEX: begin
					evs[n_ev[1:0]] = mk_ev(K_PREV_IDX, v, s.ent_cnt, '0, E_NONE);
					n_ev = n_ev + 1'b1;
					s = start_var(s, PH_SIG_LEN);
				end
				PH_SIG_LEN: begin
					evs[n_ev[1:0]] = mk_ev(K_SIG_LEN, v, s.ent_cnt, '0, E_NONE);
					n_ev = n_ev + 1'b1;
					if (over(v, lim_script)) begin
						evs[n_ev[1:0]] = mk_ev(K_ERROR, '0, '0, '0, E_SCRIPT);
						n_ev = n_ev + 1'b1;
						s.finished = 1'b1; s.phase = PH_DONE;
					end else if (v == '0) s = start_fixed(s, PH_SEQ, 4'd4);
					else s = start_payload(s, PH_SIG, v[CNT_W-1:0]);
				end
				PH_SEQ: begin
					evs[n_ev[1:0]] = mk_ev(K_SEQ, v, s.ent_cnt, '0, E_NONE);
					n_ev = n_ev + 1'b1;
					s = next_input(s);
				end
				PH_OUT_COUNT: begin
					evs[n_ev[1:0]] = mk_ev(K_OUT_COUNT, v, '0, '0, E_NONE);
					n_ev = n_ev + 1'b1;
					if (over(v, lim_out)) begin
						evs[n_ev[1:0]] = mk_ev(K_ERROR, '0, '0, '0, E_OUTPUTS);
						n_ev = n_ev + 1'b1;
						s.finished = 1'b1; s.phase = PH_DONE;
					end else begin
						s.ent_tot = v[CNT_W-1:0]; s.ent_cnt = '0;
						if (v == '0) s = after_outputs(s);
						else s = start_fixed(s, PH_AMOUNT, 4'd8);
					end
				end
				PH_AMOUNT: begin
					evs[n_ev[1:0]] = mk_ev(K_AMOUNT, v, s.ent_cnt, '0, E_NONE);
					n_ev = n_ev + 1'b1;
					s = start_var(s, PH_PK_LEN);
				end
				PH_PK_LEN: begin
					evs[n_ev[1:0]] = mk_ev(K_PK_LEN, v, s.ent_cnt, '0, E_NONE);
					n_ev = n_ev + 1'b1;
					if (over(v, lim_script)) begin
						evs[n_ev[1:0]] = mk_ev(K_ERROR, '0, '0, '0, E_SCRIPT);
						n_ev = n_ev + 1'b1;
						s.finished = 1'b1; s.phase = PH_DONE;
					end else if (v == '0) s = next_output(s);
					else s = start_payload(s, PH_PK, v[CNT_W-1:0]);
				end
				PH_WIT_COUNT: begin
					evs[n_ev[1:0]] = mk_ev(K_WIT_COUNT, v, s.ent_cnt, '0, E_NONE);
					n_ev = n_ev + 1'b1;
					if (over(v, lim_witems)) begin
						evs[n_ev[1:0]] = mk_ev(K_ERROR, '0, '0, '0, E_WIT_ITEMS);
						n_ev = n_ev + 1'b1;
						s.finished = 1'b1; s.phase = PH_DONE;
					end else begin
						s.wit_tot = v[CNT_W-1:0]; s.wit_cnt = '0;
						if (v == '0) s = next_wit_input(s);
						else s = start_var(s, PH_WIT_LEN);
					end
				end
				PH_WIT_LEN: begin
					evs[n_ev[1:0]] = mk_ev(K_WIT_LEN, v, s.ent_cnt, s.wit_cnt, E_NONE);
					n_ev = n_ev + 1'b1;
					if (over(v, lim_wlen)) begin
						evs[n_ev[1:0]] = mk_ev(K_ERROR, '0, '0, '0, E_WIT_LEN);
						n_ev = n_ev + 1'b1;
						s.finished = 1'b1; s.phase = PH_DONE;
					end else if (v == '0) s = next_item(s);
					else s = start_payload(s, PH_WIT, v[CNT_W-1:0]);
				end
				PH_LOCK: begin
					evs[n_ev[1:0]] = mk_ev(K_LOCK, {32'd0, v[31:0]}, '0, '0, E_NONE);
					n_ev = n_ev + 1'b1;
					evs[n_ev[1:0]] = mk_ev(K_ACCEPT, '0, '0, '0, E_NONE);
					n_ev = n_ev + 1'b1;
					s.finished = 1'b1; s.phase = PH_DONE;
				end
				default: ;
			endcase
		end

		// frame end: an unfinished frame is truncated; parse state restarts
		if (last_s1) begin
			if (!s.finished) begin
				evs[n_ev[1:0]] = mk_ev(K_ERROR, '0, '0, '0, E_TRUNC);
				n_ev = n_ev + 1'b1;
			end
			s = st_reset();
		end

		if (n_ev != '0) evs[n_ev[1:0] - 2'd1].last_event = 1'b1;
		st_d = s;
	end

	tx_wfp_evq u_evq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_n   (fire ? n_ev : 3'd0),
		.push_ev  (evs),
		.space_ok (space_ok),
		.evt      (out_ch)
	);

	// done phase only once the frame is closed
	a_done_finished: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == PH_DONE |-> st_q.finished)
		else $error("done phase without finished flag");

	// a pending zero exists only while deciding the marker
	a_zpend_marker: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.zpend |-> st_q.phase == PH_MARKER)
		else $error("zero pending outside marker phase");

	// a final byte always restarts the frame
	a_last_restart: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last_s1 |=> st_q.phase == PH_VERSION && !st_q.finished && !st_q.segwit)
		else $error("frame did not restart after last byte");

	// a byte never yields more events than the queue reserve
	a_ev_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> n_ev <= 3'(MAX_EV))
		else $error("too many events for one byte");

endmodule
